// File: hdl/utf8_stream_decoder_core_defines.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Used by modules that have i_clk and i_rst_n in scope; no other dependencies.
`ifndef UTF8_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UTF8SD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8sd same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define UTF8SD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8sd next-cycle check failed");

`endif

// File: hdl/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies.
package utf8sd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;
    localparam int unsigned PartW = 15;

    localparam logic [CpW-1:0]   Replacement = 21'h00FFFD;
    localparam logic [ByteW-1:0] ContMask    = 8'hC0;
    localparam logic [ByteW-1:0] ContTag     = 8'h80;
    localparam logic [ByteW-1:0] Lead2Mask   = 8'hE0;
    localparam logic [ByteW-1:0] Lead2Tag    = 8'hC0;
    localparam logic [ByteW-1:0] Lead3Mask   = 8'hF0;
    localparam logic [ByteW-1:0] Lead3Tag    = 8'hE0;
    localparam logic [ByteW-1:0] Lead4Mask   = 8'hF8;
    localparam logic [ByteW-1:0] Lead4Tag    = 8'hF0;
    localparam logic [ByteW-1:0] ContBits    = 8'h3F;
    localparam logic [ByteW-1:0] Lead2Bits   = 8'h1F;
    localparam logic [ByteW-1:0] Lead3Bits   = 8'h0F;
    localparam logic [ByteW-1:0] Lead4Bits   = 8'h07;

    // Results caused by one byte: rep_count replacement characters, then an
    // optional tail result.
    typedef struct packed {
        logic [2:0]     rep_count;
        logic           has_tail;
        logic [CpW-1:0] tail_cp;
        logic           tail_invalid;
    } t_run;

endpackage

// File: hdl/utf8sd_decode.sv
// Byte decoder and open-sequence state for the UTF-8 stream decoder.
// Depends on utf8sd_pkg and utf8_stream_decoder_core_defines.svh.
`include "utf8_stream_decoder_core_defines.svh"

module utf8sd_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [utf8sd_pkg::ByteW-1:0] i_byte,
    input  logic                       i_eos,
    input  logic                       i_advance,
    output utf8sd_pkg::t_run           o_run
);
    import utf8sd_pkg::*;

    logic [PartW-1:0] r_partial, n_partial;
    logic [1:0]       r_held, n_held;
    logic [2:0]       r_seq_len, n_seq_len;

    logic       is_cont;
    logic [2:0] held_inc;
    logic [2:0] lead_len;
    logic [PartW-1:0] lead_bits;

    always_comb begin
        is_cont  = (i_byte & ContMask) == ContTag;
        held_inc = {1'b0, r_held} + 3'd1;

        lead_len  = 3'd0;
        lead_bits = '0;
        if ((i_byte & Lead2Mask) == Lead2Tag) begin
            lead_len  = 3'd2;
            lead_bits = PartW'(i_byte & Lead2Bits);
        end else if ((i_byte & Lead3Mask) == Lead3Tag) begin
            lead_len  = 3'd3;
            lead_bits = PartW'(i_byte & Lead3Bits);
        end else if ((i_byte & Lead4Mask) == Lead4Tag) begin
            lead_len  = 3'd4;
            lead_bits = PartW'(i_byte & Lead4Bits);
        end

        o_run     = '0;
        n_partial = '0;
        n_held    = '0;
        n_seq_len = '0;

        if (r_held != 2'd0 && is_cont) begin
            if (held_inc >= r_seq_len) begin
                // complete the sequence
                o_run.has_tail = 1'b1;
                o_run.tail_cp  = {r_partial, i_byte[5:0]};
            end else if (i_eos) begin
                // string ends mid-sequence: drop everything held
                o_run.rep_count = held_inc;
            end else begin
                n_partial = {r_partial[PartW-7:0], i_byte[5:0]};
                n_held    = held_inc[1:0];
                n_seq_len = r_seq_len;
            end
        end else begin
            // flush a broken sequence, then decode this byte afresh
            o_run.rep_count = {1'b0, r_held};
            if (!i_byte[ByteW-1]) begin
                o_run.has_tail = 1'b1;
                o_run.tail_cp  = CpW'(i_byte);
            end else if (lead_len != 3'd0 && !i_eos) begin
                n_partial = lead_bits;
                n_held    = 2'd1;
                n_seq_len = lead_len;
            end else begin
                o_run.has_tail     = 1'b1;
                o_run.tail_cp      = Replacement;
                o_run.tail_invalid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_held    <= '0;
            r_seq_len <= '0;
        end else if (i_advance) begin
            r_partial <= n_partial;
            r_held    <= n_held;
            r_seq_len <= n_seq_len;
        end
    end

    `UTF8SD_ASSERT_IMP(a_idle_clean, r_held == 2'd0, r_partial == '0 && r_seq_len == 3'd0)
    `UTF8SD_ASSERT_IMP(a_held_below_len, r_held != 2'd0, r_seq_len > 3'(r_held) && r_seq_len <= 3'd4)
    `UTF8SD_ASSERT_IMP(a_run_bounded, i_advance, 4'(o_run.rep_count) + 4'(o_run.has_tail) <= 4'd4)

endmodule

// File: hdl/utf8sd_emit.sv
// Result serializer for the UTF-8 stream decoder: holds the results of one
// byte and hands them out one per transaction. Depends on utf8sd_pkg and the defines header.
`include "utf8_stream_decoder_core_defines.svh"

module utf8sd_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  utf8sd_pkg::t_run           i_run,
    input  logic                       i_run_valid,
    output logic                       o_load_ready,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [utf8sd_pkg::CpW-1:0] o_code_point,
    output logic                       o_was_invalid,
    output logic                       o_last_of_run
);
    import utf8sd_pkg::*;

    // pending results behind the output register
    logic [2:0]     r_rep, n_rep;
    logic           r_tail, n_tail;
    logic [CpW-1:0] r_tail_cp, n_tail_cp;
    logic           r_tail_inv, n_tail_inv;
    // output register
    logic           r_out_valid, n_out_valid;
    logic [CpW-1:0] r_out_cp, n_out_cp;
    logic           r_out_inv, n_out_inv;
    logic           r_out_last, n_out_last;

    logic has_pend, free, load;
    t_run src;

    always_comb begin
        has_pend     = (r_rep != 3'd0) || r_tail;
        free         = !r_out_valid || i_ready;
        o_load_ready = !has_pend && free;
        load         = i_run_valid && o_load_ready;

        src.rep_count    = r_rep;
        src.has_tail     = r_tail;
        src.tail_cp      = r_tail_cp;
        src.tail_invalid = r_tail_inv;
        if (!has_pend) begin
            src = i_run;
        end

        n_rep       = r_rep;
        n_tail      = r_tail;
        n_tail_cp   = r_tail_cp;
        n_tail_inv  = r_tail_inv;
        n_out_valid = r_out_valid;
        n_out_cp    = r_out_cp;
        n_out_inv   = r_out_inv;
        n_out_last  = r_out_last;

        if (free) begin
            n_out_valid = 1'b0;
            if ((has_pend || load) && (src.rep_count != 3'd0 || src.has_tail)) begin
                n_out_valid = 1'b1;
                n_tail_cp   = src.tail_cp;
                n_tail_inv  = src.tail_invalid;
                if (src.rep_count != 3'd0) begin
                    n_out_cp   = Replacement;
                    n_out_inv  = 1'b1;
                    n_out_last = (src.rep_count == 3'd1) && !src.has_tail;
                    n_rep      = src.rep_count - 3'd1;
                    n_tail     = src.has_tail;
                end else begin
                    n_out_cp   = src.tail_cp;
                    n_out_inv  = src.tail_invalid;
                    n_out_last = 1'b1;
                    n_rep      = 3'd0;
                    n_tail     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep       <= '0;
            r_tail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rep       <= n_rep;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail_cp  <= n_tail_cp;
        r_tail_inv <= n_tail_inv;
        r_out_cp   <= n_out_cp;
        r_out_inv  <= n_out_inv;
        r_out_last <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_code_point  = r_out_cp;
    assign o_was_invalid = r_out_inv;
    assign o_last_of_run = r_out_last;

    `UTF8SD_ASSERT_IMP(a_pend_needs_out, has_pend, r_out_valid && !r_out_last)
    `UTF8SD_ASSERT_IMP(a_pend_bounded, 1'b1, r_rep <= 3'd3)
    `UTF8SD_ASSERT_NXT(a_load_shows, load && (i_run.rep_count != 3'd0 || i_run.has_tail), r_out_valid)

endmodule

// File: hdl/utf8_stream_decoder_core.sv
// Top level of the lenient streaming UTF-8 decoder.
// Depends on utf8sd_pkg, utf8sd_decode and utf8sd_emit.
//
//  Channel   Handshake           Payload
//  input     i_valid / o_ready   i_in_byte, i_end_of_string
//  output    o_valid / i_ready   o_code_point, o_was_invalid, o_last_of_run
//
// A byte is registered at input, decoded against the open-sequence state in
// one pass, and its results go to the output register one per cycle while
// the output is not stalled. One byte per cycle while each byte gives at most
// one result and the output is not stalled; a byte with k results holds the
// input while the output register drains them.
// Synchronous reset drops all in flight; a stalled output backs up into input.

module utf8_stream_decoder_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [utf8sd_pkg::ByteW-1:0] i_in_byte,
    input  logic                       i_end_of_string,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [utf8sd_pkg::CpW-1:0] o_code_point,
    output logic                       o_was_invalid,
    output logic                       o_last_of_run
);
    import utf8sd_pkg::*;

    // input register
    logic             r_in_valid, n_in_valid;
    logic [ByteW-1:0] r_byte;
    logic             r_eos;

    logic advance;
    logic load_ready;
    t_run run;

    // Advance the held byte into the decoder when the serializer can take its
    // results; the input register refills in the same cycle.
    always_comb begin
        advance    = r_in_valid && load_ready;
        o_ready    = !r_in_valid || advance;
        n_in_valid = r_in_valid;
        if (o_ready) begin
            n_in_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Hold the payload until the transaction moves on.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_in_byte;
            r_eos  <= i_end_of_string;
        end
    end

    utf8sd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (r_byte),
        .i_eos     (r_eos),
        .i_advance (advance),
        .o_run     (run)
    );

    utf8sd_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run         (run),
        .i_run_valid   (r_in_valid),
        .o_load_ready  (load_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_point  (o_code_point),
        .o_was_invalid (o_was_invalid),
        .o_last_of_run (o_last_of_run)
    );

endmodule
